FILE: rtl/reverse_pair_counter_defines.svh
// assertion macros shared by the reverse pair counter rtl
// no dependencies; included inside module bodies after the package import
`ifndef REVERSE_PAIR_COUNTER_DEFINES_SVH
`define REVERSE_PAIR_COUNTER_DEFINES_SVH

// antecedent holds in a cycle, consequent holds in the same cycle
`define RPC_ASSERT_SAME(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rpc assertion failed");

// antecedent holds in a cycle, consequent holds in the next cycle
`define RPC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rpc assertion failed");

`endif

FILE: rtl/rpc_pkg.sv
// shared constants and controller/datapath command and status types
// no dependencies
`timescale 1ns / 1ps

package rpc_pkg;

  localparam int MAX_ITEMS = 256;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int FILL_W    = $clog2(MAX_ITEMS + 1);
  localparam int VALUE_W   = 32;
  localparam int WIDE_W    = VALUE_W + 2;
  localparam int COUNT_W   = 15;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the accepted item
    logic scan;   // step the compare scan over stored values
    logic store;  // append the held value to the memory
    logic emit;   // move the result to the output register, clear sequence
  } rpc_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;       // memory holds MAX_ITEMS values
    logic scan_done;  // every stored value has been compared
    logic last;       // held item closes the sequence
    logic out_free;   // output register can take a result this cycle
  } rpc_status_t;

endpackage

FILE: rtl/rpc_in_if.sv
// input channel: valid/ready handshake with one sequence value and its end marker
// depends on rpc_pkg
`timescale 1ns / 1ps

interface rpc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rpc_pkg::VALUE_W-1:0]  value;
  logic                                last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

FILE: rtl/rpc_out_if.sv
// result channel: valid/ready handshake with the pair count and overflow flag
// depends on rpc_pkg
`timescale 1ns / 1ps

interface rpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [rpc_pkg::COUNT_W-1:0]   pair_count;
  logic                          overflow;

  modport source (output valid, output pair_count, output overflow, input ready);
  modport sink   (input valid, input pair_count, input overflow, output ready);
endinterface

FILE: rtl/reverse_pair_counter.sv
// Reverse pair counter: counts pairs i < j with value[i] > 2 * value[j] over a sequence.
// Data flow over the input channel; one result per sequence leaves over the result channel.
// Each accepted value that fits in the memory is compared, one stored value per cycle, against
// all earlier values of the sequence held in a 256-entry memory, then appended to it.
// An item with last set closes the sequence: the pair count and overflow flag are moved
// into the output register and the sequence state clears for the next one.
// An item that fits is loaded, compared against the memory through a registered read and
// the comparator, then stored; only then is the next item accepted. A dropped item is
// only loaded, with no scan or store. The closing item then waits in the emit state until
// the output register is free and its result is loaded there.
// Values beyond 256 in one sequence are dropped and set the overflow flag.
// Reset (synchronous, rst_n low) empties the sequence and drops any pending result.
// If the receiver stalls, the result waits in the output register and the block keeps
// accepting and scanning the next sequence; it waits only when a second result is ready.
// depends on rpc_pkg, rpc_in_if, rpc_out_if, rpc_ctrl, rpc_dp
`timescale 1ns / 1ps

module reverse_pair_counter (
  input  logic      clk,
  input  logic      rst_n,
  rpc_in_if.sink    in_ch,
  rpc_out_if.source out_ch
);
  import rpc_pkg::*;

  // command and status between controller and datapath
  rpc_cmd_t    cmd;
  rpc_status_t status;

  // controller owns the input handshake and the step sequence
  rpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath holds the values, the running count and the output register
  rpc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_value       (in_ch.value),
    .in_last        (in_ch.last),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_pair_count (out_ch.pair_count),
    .out_overflow   (out_ch.overflow)
  );

endmodule

FILE: rtl/rpc_ctrl.sv
// controller: sequences accept, compare scan, store and result hand-off
// depends on rpc_pkg
`timescale 1ns / 1ps

module rpc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  input  rpc_pkg::rpc_status_t status,
  output rpc_pkg::rpc_cmd_t    cmd
);
  import rpc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (status.full) begin
            // item past the limit: no scan and no store, only the overflow flag is set
            state_nxt = in_last ? ST_EMIT : ST_IDLE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          cmd.store = 1'b1;
          state_nxt = status.last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/rpc_dp.sv
// datapath: value memory, scan index, comparator, pair counter, output register
// depends on rpc_pkg and reverse_pair_counter_defines.svh
`timescale 1ns / 1ps

module rpc_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rpc_pkg::rpc_cmd_t                   cmd,
  output rpc_pkg::rpc_status_t                status,
  input  logic signed [rpc_pkg::VALUE_W-1:0]  in_value,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rpc_pkg::COUNT_W-1:0]         out_pair_count,
  output logic                                out_overflow
);
  import rpc_pkg::*;
  `include "reverse_pair_counter_defines.svh"

  logic [VALUE_W-1:0] mem [MAX_ITEMS];

  logic [VALUE_W-1:0] value_r;
  logic               last_r;
  logic [FILL_W-1:0]  fill_r;
  logic [FILL_W-1:0]  idx_r;
  logic               cmp_vld_r;
  logic [VALUE_W-1:0] rd_data_r;
  logic [COUNT_W-1:0] count_r;
  logic               ovf_r;
  logic               out_vld_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_ovf_r;

  logic signed [WIDE_W-1:0] twice;
  logic signed [WIDE_W-1:0] stored_wide;
  logic                     hit;
  logic                     scan_rd;

  // doubled at 34 bits so the product never wraps
  assign twice       = $signed({value_r[VALUE_W-1], value_r, 1'b0});
  assign stored_wide = $signed({{2{rd_data_r[VALUE_W-1]}}, rd_data_r});
  assign hit         = cmp_vld_r && (stored_wide > twice);
  assign scan_rd     = cmd.scan && (idx_r < fill_r);

  assign status.full      = (fill_r == FILL_W'(MAX_ITEMS));
  assign status.scan_done = (idx_r == fill_r) && !cmp_vld_r;
  assign status.last      = last_r;
  assign status.out_free  = !out_vld_r || out_ready;

  assign out_valid      = out_vld_r;
  assign out_pair_count = out_count_r;
  assign out_overflow   = out_ovf_r;

  // memory port: registered read during the scan, write on store
  always_ff @(posedge clk) begin
    if (scan_rd) begin
      rd_data_r <= mem[idx_r[ADDR_W-1:0]];
    end
    if (cmd.store) begin
      mem[fill_r[ADDR_W-1:0]] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_value;
      last_r  <= in_last;
    end
    if (cmd.emit) begin
      out_count_r <= count_r;
      out_ovf_r   <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
      count_r   <= '0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r     <= '0;
        cmp_vld_r <= 1'b0;
        if (status.full) begin
          ovf_r <= 1'b1;
        end
      end else if (cmd.scan) begin
        cmp_vld_r <= scan_rd;
        if (scan_rd) begin
          idx_r <= idx_r + 1'b1;
        end
      end

      // saturating pair count
      if (hit && (count_r != COUNT_MAX)) begin
        count_r <= count_r + 1'b1;
      end

      if (cmd.store) begin
        fill_r <= fill_r + 1'b1;
      end

      if (cmd.emit) begin
        fill_r    <= '0;
        idx_r     <= '0;
        count_r   <= '0;
        ovf_r     <= 1'b0;
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  `RPC_ASSERT_SAME(a_fill_range, clk, rst_n, 1'b1, fill_r <= FILL_W'(MAX_ITEMS))
  `RPC_ASSERT_SAME(a_idx_bound, clk, rst_n, 1'b1, idx_r <= fill_r)
  `RPC_ASSERT_SAME(a_store_after_scan, clk, rst_n, cmd.store, status.scan_done && !status.full)
  `RPC_ASSERT_NEXT(a_emit_clears, clk, rst_n, cmd.emit, fill_r == '0 && count_r == '0 && !ovf_r)

endmodule

FILE: tb/rpc_checker.sv
// checker for the reverse pair counter: watches both channels, predicts each result
// and compares it field by field; depends on rpc_pkg, rpc_in_if and rpc_out_if
`timescale 1ns / 1ps

module rpc_checker (
  input  logic clk,
  input  logic rst_n,
  rpc_in_if    in_mon,
  rpc_out_if   out_mon,
  output int   err_count,
  output int   pending
);
  import rpc_pkg::*;

  typedef struct packed {
    logic [COUNT_W-1:0] pair_count;
    logic               overflow;
  } rpc_result_t;

  // values of the open sequence, in arrival order
  logic signed [VALUE_W-1:0] held_vals[$];
  logic [COUNT_W-1:0]        run_pairs;
  logic                      run_ovf;
  rpc_result_t               result_q[$];
  rpc_result_t               want;
  int                        hits;
  int                        sum;

  // earlier values strictly above twice the new one, at 34-bit width
  function automatic int pairs_above_double(logic signed [VALUE_W-1:0] v);
    logic signed [WIDE_W-1:0] twice;
    logic signed [WIDE_W-1:0] wide_s;
    int n;
    twice = {{2{v[VALUE_W-1]}}, v};
    twice = twice <<< 1;
    n = 0;
    foreach (held_vals[k]) begin
      wide_s = {{2{held_vals[k][VALUE_W-1]}}, held_vals[k]};
      if (wide_s > twice) n++;
    end
    return n;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      held_vals.delete();
      result_q.delete();
      run_pairs = '0;
      run_ovf   = 1'b0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (result_q.size() == 0) begin
          $error("result with no item expected: pair_count %0d overflow %0d",
                 out_mon.pair_count, out_mon.overflow);
          err_count++;
        end else begin
          want = result_q.pop_front();
          if (out_mon.pair_count !== want.pair_count) begin
            $error("pair_count mismatch: expected %0d, actual %0d",
                   want.pair_count, out_mon.pair_count);
            err_count++;
          end
          if (out_mon.overflow !== want.overflow) begin
            $error("overflow mismatch: expected %0d, actual %0d",
                   want.overflow, out_mon.overflow);
            err_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (held_vals.size() < MAX_ITEMS) begin
          hits = pairs_above_double(in_mon.value);
          sum  = int'(run_pairs) + hits;
          run_pairs = (sum > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(sum);
          held_vals.push_back(in_mon.value);
        end else begin
          run_ovf = 1'b1;
        end
        if (in_mon.last) begin
          result_q.push_back('{pair_count: run_pairs, overflow: run_ovf});
          held_vals.delete();
          run_pairs = '0;
          run_ovf   = 1'b0;
        end
      end
    end
    pending = result_q.size();
  end

endmodule

FILE: tb/tb.sv
// top of the reverse pair counter testbench: clock, reset, sequence stimulus and
// receiver stalls; depends on rpc_pkg, both channel interfaces, the block and rpc_checker
`timescale 1ns / 1ps

module tb;
  import rpc_pkg::*;

  localparam int LIMIT       = 400000;         // generous cycle budget
  localparam int DRAIN       = MAX_ITEMS + 16; // worst sweep plus output load
  localparam int HOLD_CYCLES = 3000;           // long receiver hold-off
  localparam int RAND_ITEMS  = 550;
  localparam int LONG_AT     = 150;            // random items before the overflow run
  localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7fffffff;
  localparam logic signed [VALUE_W-1:0] VMIN = 32'sh80000000;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SHUT} rx_mode_t;

  logic clk;
  logic rst_n;
  int   err_count;
  int   pending;
  int   cycles;
  int   burst_left;
  logic hold_req;
  logic hold_done;

  rpc_in_if  in_ch();
  rpc_out_if out_ch();

  reverse_pair_counter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rpc_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .err_count (err_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run budget, counted from time zero so the reset stretch is included
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // offer one item; the sender works in bursts with random gaps in between
  task automatic send_value(input logic signed [VALUE_W-1:0] v, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      // a quarter of the bursts follow the previous one with no gap at all
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        in_ch.value <= $urandom;          // junk payload while idle
        in_ch.last  <= $urandom_range(0, 1);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= is_last;
    // the item moves at the first rising edge that sees ready high
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_pair(input logic signed [VALUE_W-1:0] a,
                           input logic signed [VALUE_W-1:0] b);
    send_value(a, 1'b0);
    send_value(b, 1'b1);
  endtask

  // value mix: full range, small, extremes, and values near half of the previous
  // one so that the strict comparison against the doubled value sits on its edge
  function automatic logic signed [VALUE_W-1:0] pick_value(
      input logic signed [VALUE_W-1:0] prev);
    int k;
    logic signed [VALUE_W-1:0] half;
    k = $urandom_range(0, 9);
    if (k < 4) return $urandom;
    if (k < 6) return $urandom_range(0, 16) - 8;
    if (k == 6) begin
      case ($urandom_range(0, 4))
        0: return VMAX;
        1: return VMIN;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end
    half = prev >>> 1;
    return half + ($urandom_range(0, 2) - 1);
  endfunction

  task automatic send_random_seq(input int len);
    logic signed [VALUE_W-1:0] prev;
    logic signed [VALUE_W-1:0] v;
    prev = $urandom;
    for (int i = 0; i < len; i++) begin
      v = pick_value(prev);
      send_value(v, i == len - 1);
      prev = v;
    end
  endtask

  // full memory of -1: every pair qualifies, so the count reaches 32640, just under its top;
  // the extra items past the memory are dropped and flag overflow
  task automatic send_overflow_seq(input int extra);
    for (int i = 0; i < MAX_ITEMS; i++) send_value(-1, 1'b0);
    for (int i = 0; i < extra; i++) send_value($urandom, i == extra - 1);
  endtask

  // receiver: open, random and shut stretches, plus one long hold-off so the
  // block fills its output register and has to stall its input
  initial begin
    rx_mode_t mode;
    int span;
    out_ch.ready = 1'b0;
    hold_done    = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        mode = rx_mode_t'($urandom_range(0, 2));
        span = (mode == RX_SHUT) ? $urandom_range(1, 12) : $urandom_range(1, 40);
        repeat (span) begin
          @(negedge clk);
          case (mode)
            RX_OPEN:   out_ch.ready <= 1'b1;
            RX_RANDOM: out_ch.ready <= $urandom_range(0, 1);
            default:   out_ch.ready <= 1'b0;
          endcase
        end
      end
    end
  end

  // main stimulus
  initial begin
    int sent;
    int len;
    logic long_done;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.last  = 1'b0;
    rst_n       = 1'b0;
    hold_req    = 1'b0;
    burst_left  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: single-element sequences give zero
    send_value(0, 1'b1);
    send_value(VMAX, 1'b1);
    // extremes both ways; min against min needs the wide doubling
    send_pair(VMAX, VMIN);
    send_pair(VMIN, VMAX);
    send_pair(VMIN, VMIN);
    send_pair(VMAX, VMAX);
    // strict compare: equal to twice does not count, one above does
    send_pair(4, 2);
    send_pair(5, 2);
    send_pair(-4, -2);
    send_pair(-3, -2);
    // around zero
    send_pair(0, -1);
    send_pair(-1, 0);
    send_pair(1, 0);

    // random well-formed sequences, mostly short, one long run past the memory
    hold_req  = 1'b1;
    sent      = 0;
    long_done = 1'b0;
    while (sent < RAND_ITEMS) begin
      if (!long_done && sent >= LONG_AT) begin
        len = $urandom_range(1, 3);
        send_overflow_seq(len);
        sent      += MAX_ITEMS + len;
        long_done = 1'b1;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        send_random_seq(len);
        sent += len;
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // drain: every expected result out, then a quiet stretch for stray results
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
